@@ hdl/kvst_pkg.sv @@
// Shared constants, codes and transfer types of the key/value slot table.
package kvst_pkg;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned KEY_BYTES   = 16;
  localparam int unsigned VALUE_BYTES = 32;

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned VIDX_W = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
  localparam int unsigned KCNT_W = $clog2(KEY_BYTES + 1);
  localparam int unsigned VCNT_W = $clog2(VALUE_BYTES + 1);
  localparam int unsigned LEN_W  = (KCNT_W > VCNT_W) ? KCNT_W : VCNT_W;
  localparam int unsigned SLOT_W = 4;

  typedef enum logic [2:0] {
    ACT_LOOKUP  = 3'd0,
    ACT_UPD_KEY = 3'd1,
    ACT_UPD_VAL = 3'd2,
    ACT_RD_KEY  = 3'd3,
    ACT_RD_VAL  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_BAD_SLOT  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_FINISH,
    FSM_READ
  } fsm_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] in_byte;
    logic       in_has_byte;
    logic       in_last;
    logic [7:0] slot;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot_index;
    logic [7:0]        out_byte;
    logic              out_has_byte;
    logic              out_last;
  } res_t;

endpackage

@@ hdl/key_value_slot_table.sv @@
// Key/value slot table: streamed key and value buffering, slot search and read-back.
//
// Usage: an item is taken when start_i is high and busy_o is low. Key and value
// bytes (actions 0..2 without an end) are absorbed while idle and busy_o stays
// low. Ending a lookup key or an update value walks the slots through the key
// memory, one slot row per cycle, and stops at the first match. The walk first
// issues the read of row 0, then compares one row while issuing the next; a
// finish state then writes back an update and builds the status. The next item
// can be taken in the cycle in which the status appears. The walk is bounded by
// the one read port of the key row memory. A read of a slot first reads the row
// from memory, then streams one byte per cycle from the registered row; bad
// slots, empty strings and overlong keys or values answer in the cycle after
// they are taken. Each result is on res_o for exactly one cycle with res_valid_o
// high and cannot be held off. There is no clearing pass: slot lengths live in
// flops that reset to zero, and key and value rows are only ever read up to
// their stored length.
module key_value_slot_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  kvst_pkg::req_t req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output kvst_pkg::res_t res_o
);
  import kvst_pkg::*;

  // Slot storage: lengths in flops, byte rows in memories (one row per slot).
  logic [KEY_BYTES-1:0][7:0]   kmem [ENTRIES];
  logic [VALUE_BYTES-1:0][7:0] vmem [ENTRIES];
  logic [KEY_BYTES-1:0][7:0]   kmem_rd_q;
  logic [VALUE_BYTES-1:0][7:0] vmem_rd_q;
  logic [KCNT_W-1:0]           key_len_q [ENTRIES];
  logic [VCNT_W-1:0]           val_len_q [ENTRIES];

  // Pending key/value being streamed in.
  logic [KEY_BYTES-1:0][7:0]   pend_key_q;
  logic [VALUE_BYTES-1:0][7:0] pend_val_q;
  logic [KCNT_W-1:0]           pend_kcnt_q;
  logic [VCNT_W-1:0]           pend_vcnt_q;
  logic                        ovf_q;

  fsm_e state_q, state_d;

  // Walk and read sequencing.
  logic [IDX_W-1:0] walk_q, cmp_idx_q, target_q, free_idx_q, rd_slot_q;
  logic             cmp_vld_q, found_q, free_vld_q, op_upd_q, rd_key_q;
  logic [LEN_W-1:0] rd_cnt_q, rd_len_q;

  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic             accept, key_byte_in, val_byte_in, is_end, is_read;
  logic             key_full, val_full, ovf_now, bad_slot, clear_pend;
  logic [IDX_W-1:0] req_idx;
  logic [LEN_W-1:0] req_len;
  logic             kmem_re, vmem_re, mem_we;
  logic [IDX_W-1:0] kmem_ra, wr_idx;
  logic             bytes_eq, match, walk_last, cmp_free, fin_hit;
  logic [IDX_W-1:0] fin_idx;
  action_e          act;

  assign act         = action_e'(req_i.action);
  assign accept      = start_i & (state_q == FSM_IDLE);
  assign key_byte_in = accept & req_i.in_has_byte & ((act == ACT_LOOKUP) | (act == ACT_UPD_KEY));
  assign val_byte_in = accept & req_i.in_has_byte & (act == ACT_UPD_VAL);
  assign key_full    = (pend_kcnt_q == KCNT_W'(KEY_BYTES));
  assign val_full    = (pend_vcnt_q == VCNT_W'(VALUE_BYTES));
  assign ovf_now     = ovf_q | (key_byte_in & key_full) | (val_byte_in & val_full);
  assign is_end      = accept & req_i.in_last & ((act == ACT_LOOKUP) | (act == ACT_UPD_VAL));
  assign is_read     = accept & ((act == ACT_RD_KEY) | (act == ACT_RD_VAL));
  assign bad_slot    = (req_i.slot >= 8'(ENTRIES));
  assign req_idx     = req_i.slot[IDX_W-1:0];
  assign req_len     = (act == ACT_RD_KEY) ? LEN_W'(key_len_q[req_idx])
                                           : LEN_W'(val_len_q[req_idx]);

  // Slot compare on the row that came back from the key memory.
  always_comb begin
    bytes_eq = 1'b1;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if ((KCNT_W'(b) < pend_kcnt_q) && (kmem_rd_q[b] != pend_key_q[b])) begin
        bytes_eq = 1'b0;
      end
    end
  end

  assign match     = cmp_vld_q & (key_len_q[cmp_idx_q] == pend_kcnt_q) & bytes_eq;
  assign cmp_free  = cmp_vld_q & (key_len_q[cmp_idx_q] == '0);
  assign walk_last = cmp_vld_q & (cmp_idx_q == IDX_W'(ENTRIES - 1));
  assign fin_hit   = found_q | free_vld_q;
  assign fin_idx   = found_q ? target_q : free_idx_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (is_end && !ovf_now) begin
          state_d = FSM_WALK;
        end else if (is_read && !bad_slot && (req_len != '0)) begin
          state_d = FSM_READ;
        end
      end
      FSM_WALK: begin
        if (match || walk_last) begin
          state_d = FSM_FINISH;
        end
      end
      FSM_FINISH: state_d = FSM_IDLE;
      FSM_READ: begin
        if (rd_cnt_q == rd_len_q - LEN_W'(1)) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Outputs: memory controls and next result.
  always_comb begin
    kmem_re     = 1'b0;
    vmem_re     = 1'b0;
    kmem_ra     = walk_q;
    mem_we      = 1'b0;
    wr_idx      = fin_idx;
    clear_pend  = 1'b0;
    res_valid_d = 1'b0;
    res_d       = '0;
    case (state_q)
      FSM_IDLE: begin
        if (is_end && ovf_now) begin
          res_valid_d     = 1'b1;
          res_d.status    = ST_TOO_LONG;
          res_d.out_last  = 1'b1;
          clear_pend      = 1'b1;
        end else if (is_read) begin
          if (bad_slot) begin
            res_valid_d    = 1'b1;
            res_d.status   = ST_BAD_SLOT;
            res_d.out_last = 1'b1;
          end else if (req_len == '0) begin
            res_valid_d      = 1'b1;
            res_d.status     = ST_OK;
            res_d.slot_index = SLOT_W'(req_idx);
            res_d.out_last   = 1'b1;
          end else begin
            kmem_re = (act == ACT_RD_KEY);
            vmem_re = (act == ACT_RD_VAL);
            kmem_ra = req_idx;
          end
        end
      end
      FSM_WALK: kmem_re = 1'b1;
      FSM_FINISH: begin
        res_valid_d    = 1'b1;
        res_d.out_last = 1'b1;
        clear_pend     = 1'b1;
        if (op_upd_q) begin
          if (fin_hit) begin
            mem_we           = 1'b1;
            res_d.status     = ST_OK;
            res_d.slot_index = SLOT_W'(fin_idx);
          end else begin
            res_d.status = ST_FULL;
          end
        end else if (found_q) begin
          res_d.status     = ST_OK;
          res_d.slot_index = SLOT_W'(target_q);
        end else begin
          res_d.status = ST_NOT_FOUND;
        end
      end
      FSM_READ: begin
        res_valid_d        = 1'b1;
        res_d.status       = ST_OK;
        res_d.slot_index   = SLOT_W'(rd_slot_q);
        res_d.out_has_byte = 1'b1;
        res_d.out_last     = (rd_cnt_q == rd_len_q - LEN_W'(1));
        res_d.out_byte     = rd_key_q ? kmem_rd_q[rd_cnt_q[KIDX_W-1:0]]
                                      : vmem_rd_q[rd_cnt_q[VIDX_W-1:0]];
      end
      default: ;
    endcase
  end

  // Key and value row memories; only one item is in flight, so a row written
  // in FINISH is never read in the same cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      kmem[wr_idx] <= pend_key_q;
    end
    if (kmem_re) begin
      kmem_rd_q <= kmem[kmem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vmem[wr_idx] <= pend_val_q;
    end
    if (vmem_re) begin
      vmem_rd_q <= vmem[req_idx];
    end
  end

  // Pending payload bytes.
  always_ff @(posedge clk_i) begin
    if (key_byte_in && !key_full) begin
      pend_key_q[pend_kcnt_q[KIDX_W-1:0]] <= req_i.in_byte;
    end
    if (val_byte_in && !val_full) begin
      pend_val_q[pend_vcnt_q[VIDX_W-1:0]] <= req_i.in_byte;
    end
    res_q <= res_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      pend_kcnt_q <= '0;
      pend_vcnt_q <= '0;
      ovf_q       <= 1'b0;
      walk_q      <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      target_q    <= '0;
      found_q     <= 1'b0;
      free_idx_q  <= '0;
      free_vld_q  <= 1'b0;
      op_upd_q    <= 1'b0;
      rd_key_q    <= 1'b0;
      rd_slot_q   <= '0;
      rd_cnt_q    <= '0;
      rd_len_q    <= '0;
      res_valid_q <= 1'b0;
      for (int s = 0; s < ENTRIES; s++) begin
        key_len_q[s] <= '0;
        val_len_q[s] <= '0;
      end
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;

      if (clear_pend) begin
        pend_kcnt_q <= '0;
        pend_vcnt_q <= '0;
        ovf_q       <= 1'b0;
      end else begin
        if (key_byte_in) begin
          if (key_full) ovf_q <= 1'b1;
          else pend_kcnt_q <= pend_kcnt_q + KCNT_W'(1);
        end
        if (val_byte_in) begin
          if (val_full) ovf_q <= 1'b1;
          else pend_vcnt_q <= pend_vcnt_q + VCNT_W'(1);
        end
      end

      if (state_q == FSM_IDLE) begin
        walk_q     <= '0;
        cmp_vld_q  <= 1'b0;
        found_q    <= 1'b0;
        free_vld_q <= 1'b0;
        op_upd_q   <= (act == ACT_UPD_VAL);
        rd_key_q   <= (act == ACT_RD_KEY);
        rd_slot_q  <= req_idx;
        rd_len_q   <= req_len;
        rd_cnt_q   <= '0;
      end

      // One slot row issued and one compared per cycle.
      if (state_q == FSM_WALK) begin
        walk_q    <= walk_q + IDX_W'(1);
        cmp_idx_q <= walk_q;
        cmp_vld_q <= 1'b1;
        if (match) begin
          found_q  <= 1'b1;
          target_q <= cmp_idx_q;
        end
        if (cmp_free && !free_vld_q) begin
          free_vld_q <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end

      if (state_q == FSM_READ) begin
        rd_cnt_q <= rd_cnt_q + LEN_W'(1);
      end

      if (mem_we) begin
        key_len_q[wr_idx] <= pend_kcnt_q;
        val_len_q[wr_idx] <= pend_vcnt_q;
      end
    end
  end

  assign busy_o      = (state_q != FSM_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_finish_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_FINISH |=> state_q == FSM_IDLE)
    else $error("finish state held");

  a_key_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_kcnt_q <= KCNT_W'(KEY_BYTES))
    else $error("pending key count overrun");

  a_val_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vcnt_q <= VCNT_W'(VALUE_BYTES))
    else $error("pending value count overrun");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_READ |-> rd_cnt_q < rd_len_q)
    else $error("read-back past stored length");

  a_walk_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_WALK |=> !res_valid_q)
    else $error("result during slot walk");

endmodule

@@ sim/key_value_slot_table_tb.sv @@
// Testbench for the key/value slot table: directed and random transfers against a local model.
module key_value_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kvst_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o, res_valid_o;
  res_t res_o;

  key_value_slot_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always #6 clk_i = ~clk_i;

  // Local copy of the table state.
  logic [4:0] key_len [ENTRIES];
  logic [7:0] key_mem [ENTRIES][KEY_BYTES];
  logic [5:0] val_len [ENTRIES];
  logic [7:0] val_mem [ENTRIES][VALUE_BYTES];
  logic [7:0] pend_key [KEY_BYTES];
  logic [7:0] pend_val [VALUE_BYTES];
  int unsigned pend_key_cnt, pend_val_cnt;
  bit overflow;

  res_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit watchdog_fired = 1'b0;

  function automatic res_t mk_res(status_e st, logic [3:0] idx, logic [7:0] b,
                                  logic has, logic last);
    res_t r;
    r.status = st; r.slot_index = idx; r.out_byte = b;
    r.out_has_byte = has; r.out_last = last;
    return r;
  endfunction

  function automatic int find_pending_key();
    bit same;
    for (int s = 0; s < ENTRIES; s++) begin
      if (key_len[s] == pend_key_cnt) begin
        same = 1'b1;
        for (int i = 0; i < pend_key_cnt; i++)
          if (key_mem[s][i] != pend_key[i]) same = 1'b0;
        if (same) return s;
      end
    end
    return -1;
  endfunction

  function automatic void clear_pending();
    pend_key_cnt = 0; pend_val_cnt = 0; overflow = 1'b0;
  endfunction

  // Predicts the results of one accepted item and updates the local state.
  function automatic void predict_table(req_t r);
    int s;
    int unsigned len;
    if (r.action <= ACT_UPD_VAL) begin
      if (r.in_has_byte) begin
        if (r.action != ACT_UPD_VAL) begin
          if (pend_key_cnt < KEY_BYTES) pend_key[pend_key_cnt++] = r.in_byte;
          else overflow = 1'b1;
        end else begin
          if (pend_val_cnt < VALUE_BYTES) pend_val[pend_val_cnt++] = r.in_byte;
          else overflow = 1'b1;
        end
      end
      if (!r.in_last || r.action == ACT_UPD_KEY) return;
      if (overflow) begin
        expected_results.push_back(mk_res(ST_TOO_LONG, 0, 0, 0, 1));
        clear_pending();
        return;
      end
      s = find_pending_key();
      if (r.action == ACT_LOOKUP) begin
        if (s < 0) expected_results.push_back(mk_res(ST_NOT_FOUND, 0, 0, 0, 1));
        else expected_results.push_back(mk_res(ST_OK, 4'(s), 0, 0, 1));
        clear_pending();
        return;
      end
      if (s < 0)
        for (int t = 0; t < ENTRIES; t++)
          if (key_len[t] == 0) begin
            s = t;
            break;
          end
      if (s < 0) begin
        expected_results.push_back(mk_res(ST_FULL, 0, 0, 0, 1));
      end else begin
        for (int i = 0; i < pend_val_cnt; i++) val_mem[s][i] = pend_val[i];
        for (int i = 0; i < pend_key_cnt; i++) key_mem[s][i] = pend_key[i];
        val_len[s] = 6'(pend_val_cnt);
        key_len[s] = 5'(pend_key_cnt);
        expected_results.push_back(mk_res(ST_OK, 4'(s), 0, 0, 1));
      end
      clear_pending();
    end else if (r.action == ACT_RD_KEY || r.action == ACT_RD_VAL) begin
      if (r.slot >= ENTRIES) begin
        expected_results.push_back(mk_res(ST_BAD_SLOT, 0, 0, 0, 1));
        return;
      end
      len = (r.action == ACT_RD_KEY) ? key_len[r.slot] : val_len[r.slot];
      if (len == 0) expected_results.push_back(mk_res(ST_OK, r.slot[3:0], 0, 0, 1));
      for (int i = 0; i < len; i++)
        expected_results.push_back(mk_res(ST_OK, r.slot[3:0],
          (r.action == ACT_RD_KEY) ? key_mem[r.slot][i] : val_mem[r.slot][i],
          1, i + 1 == len));
    end
  endfunction

  // Sender burst/gap pattern.
  int unsigned burst_left = 0;

  // Sends one item; random gaps between bursts.
  task automatic send_item(logic [2:0] act, logic [7:0] b, logic has, logic last,
                           logic [7:0] slot);
    req_t r;
    r.action = act; r.in_byte = b; r.in_has_byte = has;
    r.in_last = last; r.slot = slot;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_table(r);
  endtask

  task automatic stop_sending();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_string(logic [2:0] act, int unsigned len, logic [7:0] seed);
    if (len == 0) send_item(act, 8'($urandom), 1'b0, act != ACT_UPD_KEY, 8'($urandom));
    for (int i = 0; i < len; i++)
      send_item(act, 8'(seed + i), 1'b1, i + 1 == len && act != ACT_UPD_KEY,
                8'($urandom));
  endtask

  // An empty key sends one flagless key item, which changes nothing.
  task automatic send_update(int unsigned klen, logic [7:0] kseed,
                             int unsigned vlen, logic [7:0] vseed);
    send_string(ACT_UPD_KEY, klen, kseed);
    send_string(ACT_UPD_VAL, vlen, vseed);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_results.size() != 0 && !watchdog_fired) @(posedge clk_i);
    repeat (ENTRIES + 4) @(posedge clk_i);
  endtask

  task automatic test_empty_and_extremes();
    send_string(ACT_LOOKUP, 0, 0);                  // empty key hits first free slot
    send_update(0, 0, 3, 8'hf0);                    // empty key update, slot stays free
    send_item(ACT_RD_VAL, 0, 0, 0, 0);
    send_update(KEY_BYTES, 8'hf8, VALUE_BYTES, 8'he0); // full-length key and value
    send_string(ACT_LOOKUP, KEY_BYTES, 8'hf8);
    send_item(ACT_RD_KEY, 8'hff, 1, 1, 0);
    send_item(ACT_RD_VAL, 0, 0, 0, 0);
    send_item(ACT_RD_KEY, 0, 0, 0, 8'hff);          // bad slot
    send_item(ACT_RD_VAL, 0, 0, 0, ENTRIES);
    send_item(ACT_RD_KEY, 0, 0, 0, 5);              // empty string read
    send_item(3'd7, 8'h55, 1, 1, 0);                // unused action
    send_item(3'd5, 8'haa, 1, 1, 0);
    send_item(ACT_LOOKUP, 0, 0, 0, 0);              // no byte, no end
    wait_drained();
  endtask

  task automatic test_too_long();
    send_string(ACT_LOOKUP, KEY_BYTES + 1, 8'h10);
    send_update(2, 8'h40, VALUE_BYTES + 1, 0);
    send_string(ACT_LOOKUP, 3, 8'h40);              // not found
    wait_drained();
  endtask

  task automatic test_shared_and_full();
    for (int i = 0; i < ENTRIES + 1; i++) send_update(1, 8'(8'h80 + i), 1, 8'(i));
    send_string(ACT_UPD_KEY, 1, 8'h83);             // shared key buffer, lookup consumes it
    send_string(ACT_LOOKUP, 0, 0);
    send_update(1, 8'h84, 2, 8'h33);                // overwrite existing
    send_item(ACT_RD_VAL, 0, 0, 0, 4);
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned kind;
    for (int n = 0; n < 8; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) send_update($urandom_range(0, 4), 8'($urandom_range(0, 3) << 6),
                                $urandom_range(0, 6), 8'($urandom));
      else if (kind < 6) send_string(ACT_LOOKUP, $urandom_range(0, 4),
                                     8'($urandom_range(0, 3) << 6));
      else if (kind < 9) send_item(3'($urandom_range(ACT_RD_KEY, ACT_RD_VAL)),
                                   8'($urandom), 1'($urandom), 1'($urandom),
                                   8'($urandom_range(0, 20)));
      else send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                     1'($urandom), 8'($urandom));
      if (n == 4) wait_drained();                   // sender waits for all results
    end
    wait_drained();
  endtask

  // Result checker: every strobed result must match the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result act=%p", $realtime, res_o);
        error_count++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (res_o.status !== e.status)
          $display("%0t: status exp %0d got %0d", $realtime, e.status, res_o.status);
        if (res_o.slot_index !== e.slot_index)
          $display("%0t: slot_index exp %0d got %0d", $realtime, e.slot_index,
                   res_o.slot_index);
        if (res_o.out_byte !== e.out_byte)
          $display("%0t: out_byte exp %0h got %0h", $realtime, e.out_byte, res_o.out_byte);
        if (res_o.out_has_byte !== e.out_has_byte)
          $display("%0t: out_has_byte exp %0b got %0b", $realtime, e.out_has_byte,
                   res_o.out_has_byte);
        if (res_o.out_last !== e.out_last)
          $display("%0t: out_last exp %0b got %0b", $realtime, e.out_last, res_o.out_last);
        if (res_o !== e) error_count++;
      end
    end
  end

  // Watchdog: cycles with no transfer in either direction.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      watchdog_fired = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < ENTRIES; s++) begin
      key_len[s] = 0; val_len[s] = 0;
    end
    clear_pending();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_extremes();
    test_too_long();
    test_shared_and_full();
    test_random();
    if (expected_results.size() != 0) error_count++;
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
